@@ hw/rtl/bmri_pkg.sv @@
// Package: payload types, register indexes, modes and addresses for the raster bus memory.
`timescale 1ns / 1ps
package bmri_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [63:0] now_cycles;
    logic        host_irq;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_level;
    logic [8:0] raster_line;
  } out_item_t;

  typedef struct packed {
    logic [7:0] cycles_per_line;
    logic [8:0] raster_lines;
    logic       use_cycle_source;
  } cfg_t;

  localparam logic [1:0] CfgCyclesPerLine = 2'd0;
  localparam logic [1:0] CfgRasterLines   = 2'd1;
  localparam logic [1:0] CfgUseCycleSrc   = 2'd2;

  localparam logic [2:0] ModeRead    = 3'd0;
  localparam logic [2:0] ModeWrite   = 3'd1;
  localparam logic [2:0] ModeIrq     = 3'd2;
  localparam logic [2:0] ModeRaster  = 3'd3;
  localparam logic [2:0] ModeRestart = 3'd4;

  localparam logic [15:0] AddrRasterLo = 16'hD012;
  localparam logic [15:0] AddrRasterHi = 16'hD011;
  localparam logic [15:0] AddrIrqFlag  = 16'hD019;
  localparam logic [15:0] AddrIrqMask  = 16'hD01A;

  localparam int unsigned MemAw = 16;

endpackage

@@ hw/rtl/bmri_divu.sv @@
// Serial 64-by-9 bit unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bmri_divu
  import bmri_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [8:0]  divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o,
  output logic [8:0]  rem_o
);

  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quot_q, quot_d;
  logic [8:0]  rem_q, rem_d;
  logic [8:0]  div_q, div_d;
  logic [9:0]  trial;

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quot_q[63]};
    if (start_i) begin
      cnt_d  = 7'd64;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = (divisor_i == '0) ? 9'd1 : divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 7'd1;
      if (trial >= {1'b0, div_q}) begin
        rem_d  = 9'(trial - {1'b0, div_q});
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial[8:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/bmri_mem.sv @@
// 64K-byte synchronous RAM, one port, registered read data.
`timescale 1ns / 1ps
module bmri_mem
  import bmri_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [MemAw-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [2**MemAw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ hw/rtl/bus_memory_with_raster_irq.sv @@
// Top level: bus memory with raster line readout and raster compare interrupt latch.
//
//  channel | dir | payload     | handshake
//  in      | in  | in_item_t   | in_valid_i / in_ready_o
//  out     | out | out_item_t  | out_valid_o / out_ready_i
//  cfg     | in  | idx, data   | cfg_valid_i / cfg_ready_o
//
// After reset a clearing pass writes zero over all 65536 bytes (no item taken).
// Every item runs two serial divides (cycle count by cycles_per_line, then by raster lines),
// then memory reads of raster lo, raster hi, irq mask and item address, then the finish.
// The result register holds an item until taken; the next item is taken no earlier than
// the cycle after it empties, so items never overlap. cfg is always ready.
`timescale 1ns / 1ps
module bus_memory_with_raster_irq
  import bmri_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StDivA  = 4'd2;
  localparam logic [3:0] StWaitA = 4'd3;
  localparam logic [3:0] StWaitB = 4'd5;
  localparam logic [3:0] StRdLo  = 4'd6;
  localparam logic [3:0] StRdHi  = 4'd7;
  localparam logic [3:0] StRdMsk = 4'd8;
  localparam logic [3:0] StRdAdr = 4'd9;
  localparam logic [3:0] StFin   = 4'd10;
  localparam logic [3:0] StWait1 = 4'd11;

  logic [3:0]  st_q, st_d;
  cfg_t        cfg_q;
  in_item_t    it_q;
  logic [31:0] acc_q, acc_d;
  logic [63:0] seen_q, seen_d;
  logic        latch_q, latch_d;
  logic        ov_q, ov_d;
  out_item_t   od_q, od_d;
  logic [15:0] clr_q, clr_d;
  logic [63:0] nowl_q, nowl_d;
  logic [8:0]  line_q, line_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d;

  logic        div_start, div_busy;
  logic [63:0] div_dend, div_quot;
  logic [8:0]  div_sor, div_rem;
  logic        m_we;
  logic [15:0] m_addr;
  logic [7:0]  m_wdata, m_rdata;

  bmri_divu u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dend), .divisor_i(div_sor),
    .busy_o(div_busy), .quot_o(div_quot), .rem_o(div_rem)
  );

  bmri_mem u_mem (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wdata), .rdata_o(m_rdata)
  );

  logic        counts, use_ext, adv, is_raster_rd;
  logic [8:0]  lines_eff, cmp;
  logic [63:0] first, span;
  logic [9:0]  delta;
  logic [8:0]  frm;
  logic        hit, lat_now;

  assign counts  = (it_q.mode == ModeRead) || (it_q.mode == ModeWrite) ||
                   (it_q.mode == ModeRaster);
  assign use_ext = cfg_q.use_cycle_source;
  assign is_raster_rd = (it_q.mode == ModeRead) &&
                        ((it_q.address == AddrRasterLo) || (it_q.address == AddrRasterHi));
  assign adv = use_ext && ((it_q.mode == ModeIrq) ||
               (((it_q.mode == ModeRead) || (it_q.mode == ModeWrite)) &&
                (it_q.address == AddrIrqFlag)));
  assign lines_eff = (cfg_q.raster_lines == '0) ? 9'd1 : cfg_q.raster_lines;
  assign cmp   = {hi_q[7], lo_q};
  assign first = seen_q + 64'd1;
  assign span  = nowl_q - first;
  // frm = first mod lines, from div B remainder of seen: (seen_rem + 1) mod lines
  always_comb begin
    frm = (line_q + 9'd1 >= lines_eff) ? 9'(line_q + 9'd1 - lines_eff) : 9'(line_q + 9'd1);
    delta = (cmp >= frm) ? 10'(cmp - frm) : 10'({1'b0, cmp} + {1'b0, lines_eff} - {1'b0, frm});
  end
  assign hit = (nowl_q > seen_q) && (cmp < lines_eff) && ({54'd0, delta} <= span);
  assign lat_now = adv ? (latch_q | hit) : latch_q;

  assign in_ready_o  = (st_q == StIdle) && !ov_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    st_d = st_q; acc_d = acc_q; seen_d = seen_q; latch_d = latch_q;
    ov_d = ov_q; od_d = od_q; clr_d = clr_q; nowl_d = nowl_q; line_d = line_q;
    lo_d = lo_q; hi_d = hi_q;
    div_start = 1'b0; div_dend = '0; div_sor = {1'b0, cfg_q.cycles_per_line};
    m_we = 1'b0; m_addr = it_q.address; m_wdata = it_q.write_data;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      StClear: begin
        m_we = 1'b1; m_addr = clr_q; m_wdata = '0;
        clr_d = clr_q + 16'd1;
        if (clr_q == 16'hFFFF) st_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) st_d = StDivA;
      end
      StDivA: begin
        if (counts) acc_d = acc_q + 32'd1;
        div_start = 1'b1;
        div_dend = use_ext ? it_q.now_cycles : {32'd0, counts ? acc_q + 32'd1 : acc_q};
        st_d = StWaitA;
      end
      StWaitA: begin
        if (!div_busy) begin
          nowl_d = div_quot;
          div_start = 1'b1;
          div_sor = lines_eff;
          div_dend = is_raster_rd || (it_q.mode == ModeRaster) ? div_quot : seen_q;
          st_d = StWaitB;
        end
      end
      StWaitB: begin
        if (!div_busy) begin
          line_d = div_rem;
          m_addr = AddrRasterLo;
          st_d = StRdLo;
        end
      end
      StRdLo: begin
        lo_d = m_rdata;
        m_addr = AddrRasterHi;
        st_d = StRdHi;
      end
      StRdHi: begin
        hi_d = m_rdata;
        m_addr = AddrIrqMask;
        st_d = StRdMsk;
      end
      StRdMsk: begin
        // mask byte kept in read_data until the finish
        od_d.read_data = m_rdata;
        m_addr = it_q.address;
        st_d = StRdAdr;
      end
      StRdAdr: begin
        m_addr = it_q.address;
        st_d = StWait1;
      end
      StWait1: begin
        st_d = StFin;
      end
      StFin: begin
        od_d.irq_level = 1'b0; od_d.raster_line = '0;
        st_d = StIdle; ov_d = 1'b1;
        case (it_q.mode)
          ModeRead: begin
            if (it_q.address == AddrRasterLo) od_d.read_data = line_q[7:0];
            else if (it_q.address == AddrRasterHi)
              od_d.read_data = {line_q[8], hi_q[6:0]};
            else if (adv) begin
              od_d.read_data = {lat_now & od_q.read_data[0], 3'b111, 3'b000, lat_now};
            end else od_d.read_data = m_rdata;
            if (adv) begin
              latch_d = lat_now;
              if (nowl_q > seen_q) seen_d = nowl_q;
            end
          end
          ModeWrite: begin
            od_d.read_data = '0;
            m_we = 1'b1;
            if (adv) begin
              latch_d = lat_now & ~it_q.write_data[0];
              if (nowl_q > seen_q) seen_d = nowl_q;
            end
          end
          ModeIrq: begin
            od_d.read_data = '0;
            od_d.irq_level = it_q.host_irq | (adv & lat_now & od_q.read_data[0]);
            if (adv) begin
              latch_d = lat_now;
              if (nowl_q > seen_q) seen_d = nowl_q;
            end
          end
          ModeRaster: begin
            od_d.read_data = '0;
            od_d.raster_line = line_q;
          end
          ModeRestart: begin
            od_d.read_data = '0;
            latch_d = 1'b0;
            seen_d = use_ext ? nowl_q : 64'd0;
          end
          default: od_d.read_data = '0;
        endcase
      end
      default: st_d = StIdle;
    endcase
  end

  // line_q is loaded with the div B remainder in StWaitB; for advance it is seen mod lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StClear;
      clr_q   <= '0;
      acc_q   <= '0;
      seen_q  <= '0;
      latch_q <= 1'b0;
      ov_q    <= 1'b0;
      cfg_q   <= '{cycles_per_line: 8'd63, raster_lines: 9'd312, use_cycle_source: 1'b0};
    end else begin
      st_q    <= st_d;
      clr_q   <= clr_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      latch_q <= latch_d;
      ov_q    <= ov_d;
      if (cfg_valid_i) begin
        case (cfg_idx_i)
          CfgCyclesPerLine: cfg_q.cycles_per_line  <= cfg_data_i[7:0];
          CfgRasterLines:   cfg_q.raster_lines     <= cfg_data_i[8:0];
          CfgUseCycleSrc:   cfg_q.use_cycle_source <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) it_q <= in_data_i;
    od_q   <= od_d;
    nowl_q <= nowl_d;
    line_q <= line_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

endmodule
